@@ rtl/flux_interval_capture_ring_macros.svh @@
`ifndef FLUX_INTERVAL_CAPTURE_RING_MACROS_SVH
`define FLUX_INTERVAL_CAPTURE_RING_MACROS_SVH

// same-cycle implication, disabled during reset
`define FIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fic assertion failed");

// next-cycle implication, disabled during reset
`define FIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fic assertion failed");

`endif

@@ rtl/fic_pkg.sv @@
`default_nettype none
package fic_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int MAX_READ     = 64;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = 7;
    localparam int DATA_W       = 8;
    localparam int CMP_W        = (PTR_W > LEN_W) ? PTR_W : LEN_W;
    localparam int CMDQ_DEPTH   = 2;
    localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [LEN_W-1:0]   length;
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } back_state_t;

endpackage
`default_nettype wire

@@ rtl/fic_ram.sv @@
`default_nettype none
module fic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/fic_front.sv @@
`default_nettype none
module fic_front
    import fic_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic [1:0]         action,
    input  wire logic [LEN_W-1:0]   read_length,
    output logic                    push,
    output cmd_t                    push_cmd,
    input  wire logic               queue_full
);

    logic front_valid_reg;
    logic front_valid_next;
    cmd_t front_cmd_reg;
    cmd_t front_cmd_next;
    logic accept;

    assign push       = front_valid_reg && !queue_full;
    assign push_cmd   = front_cmd_reg;
    assign item_ready = !front_valid_reg || !queue_full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_cmd_next   = front_cmd_reg;
        if (push)
        begin
            front_valid_next = 1'b0;
        end
        if (accept)
        begin
            front_valid_next      = 1'b1;
            front_cmd_next.action = action_t'(action);
            // saturate the request
            if (read_length > LEN_W'(MAX_READ))
            begin
                front_cmd_next.length = LEN_W'(MAX_READ);
            end
            else
            begin
                front_cmd_next.length = read_length;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_cmd_reg <= front_cmd_next;
    end

endmodule
`default_nettype wire

@@ rtl/fic_cmd_queue.sv @@
`default_nettype none
module fic_cmd_queue
    import fic_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire cmd_t   push_cmd,
    output logic        full,
    input  wire logic   pop,
    output cmd_t        head,
    output logic        not_empty
);

    cmd_t                entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  wr_ptr_reg;
    logic [CMDQ_AW-1:0]  wr_ptr_next;
    logic [CMDQ_AW-1:0]  rd_ptr_reg;
    logic [CMDQ_AW-1:0]  rd_ptr_next;
    logic [CMDQ_AW:0]    count_reg;
    logic [CMDQ_AW:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/fic_back.sv @@
`default_nettype none
`include "flux_interval_capture_ring_macros.svh"
module fic_back
    import fic_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    input  wire logic               cmd_valid,
    output logic                    cmd_pop,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic [DATA_W-1:0]       data,
    output logic                    data_valid,
    output logic                    last
);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              data_valid;
        logic              last;
    } out_beat_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(BUFFER_DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [DATA_W-1:0]  count_reg;
    logic [DATA_W-1:0]  count_next;
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   wp_next;
    logic [PTR_W-1:0]   rp_reg;
    logic [PTR_W-1:0]   rp_next;
    logic [LEN_W-1:0]   remaining_reg;
    logic [LEN_W-1:0]   remaining_next;
    logic               inflight_valid_reg;
    logic               inflight_ram_reg;
    logic               inflight_last_reg;
    out_beat_t          out_entry_reg [2];
    logic               out_head_reg;
    logic               out_tail_reg;
    logic [1:0]         out_count_reg;
    logic [1:0]         out_count_next;

    logic               credit;
    logic               issue;
    logic               issue_ram;
    logic               issue_last;
    logic               ram_we;
    logic               ram_re;
    logic [DATA_W-1:0]  ram_rdata;
    logic [PTR_W-1:0]   fill;
    logic [CMP_W-1:0]   fill_ext;
    logic [CMP_W-1:0]   req_ext;
    logic [LEN_W-1:0]   read_n;
    logic               out_push;
    logic               out_pop;
    out_beat_t          push_beat;

    fic_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (count_reg),
        .rd_en   (ram_re),
        .rd_addr (rp_reg),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            fill = wp_reg - rp_reg;
        end
        else
        begin
            fill = PTR_W'(BUFFER_DEPTH) - rp_reg + wp_reg;
        end
        fill_ext = CMP_W'(fill);
        req_ext  = CMP_W'(cmd.length);
        read_n   = (req_ext < fill_ext) ? cmd.length : LEN_W'(fill_ext);
    end

    assign credit = ({1'b0, out_count_reg} + {2'b00, inflight_valid_reg}) < 3'd2;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        remaining_next = remaining_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        issue          = 1'b0;
        issue_ram      = 1'b0;
        issue_last     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.action)
                        ACT_TICK:
                        begin
                            count_next = count_reg + 1'b1;
                            cmd_pop    = 1'b1;
                        end
                        ACT_EDGE:
                        begin
                            ram_we     = 1'b1;
                            count_next = '0;
                            wp_next    = ring_next(wp_reg);
                            cmd_pop    = 1'b1;
                        end
                        ACT_READ:
                        begin
                            if (read_n == '0)
                            begin
                                // empty ring or zero-length request: one invalid beat
                                if (credit)
                                begin
                                    issue      = 1'b1;
                                    issue_last = 1'b1;
                                    cmd_pop    = 1'b1;
                                end
                            end
                            else
                            begin
                                remaining_next = read_n;
                                state_next     = ST_READ;
                                cmd_pop        = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            wp_next    = '0;
                            rp_next    = '0;
                            cmd_pop    = 1'b1;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (credit)
                begin
                    issue          = 1'b1;
                    issue_ram      = 1'b1;
                    ram_re         = 1'b1;
                    issue_last     = (remaining_reg == LEN_W'(1));
                    rp_next        = ring_next(rp_reg);
                    remaining_next = remaining_reg - 1'b1;
                    if (remaining_reg == LEN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_push             = inflight_valid_reg;
    assign out_pop              = result_valid && result_ready;
    assign push_beat.data       = inflight_ram_reg ? ram_rdata : '0;
    assign push_beat.data_valid = inflight_ram_reg;
    assign push_beat.last       = inflight_last_reg;

    always_comb
    begin
        case ({out_push, out_pop})
            2'b10:   out_count_next = out_count_reg + 1'b1;
            2'b01:   out_count_next = out_count_reg - 1'b1;
            default: out_count_next = out_count_reg;
        endcase
    end

    assign result_valid = (out_count_reg != 2'd0);
    assign data         = out_entry_reg[out_head_reg].data;
    assign data_valid   = out_entry_reg[out_head_reg].data_valid;
    assign last         = out_entry_reg[out_head_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            count_reg          <= '0;
            wp_reg             <= '0;
            rp_reg             <= '0;
            remaining_reg      <= '0;
            inflight_valid_reg <= 1'b0;
            out_head_reg       <= 1'b0;
            out_tail_reg       <= 1'b0;
            out_count_reg      <= 2'd0;
        end
        else
        begin
            state_reg          <= state_next;
            count_reg          <= count_next;
            wp_reg             <= wp_next;
            rp_reg             <= rp_next;
            remaining_reg      <= remaining_next;
            inflight_valid_reg <= issue;
            out_count_reg      <= out_count_next;
            if (out_push)
            begin
                out_tail_reg <= !out_tail_reg;
            end
            if (out_pop)
            begin
                out_head_reg <= !out_head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        inflight_ram_reg  <= issue_ram;
        inflight_last_reg <= issue_last;
        if (out_push)
        begin
            out_entry_reg[out_tail_reg] <= push_beat;
        end
    end

    `FIC_ASSERT_SAME(a_credit_bound, clk, rst_n, 1'b1,
        ({1'b0, out_count_reg} + {2'b00, inflight_valid_reg}) <= 3'd2)
    `FIC_ASSERT_SAME(a_read_has_work, clk, rst_n, state_reg == ST_READ,
        remaining_reg != '0)
    `FIC_ASSERT_NEXT(a_last_ends_read, clk, rst_n, issue && issue_last,
        state_reg == ST_IDLE && inflight_last_reg)

endmodule
`default_nettype wire

@@ rtl/flux_interval_capture_ring.sv @@
// Flux interval capture ring.
// Input channel (item_valid/item_ready) carries action and read_length:
// tick advances the 8-bit interval counter, flux edge stores the counter
// byte in the ring and restarts it, read streams the oldest bytes, clear
// zeroes the counter and both ring pointers.
// Output channel (result_valid/result_ready) carries data, data_valid, last.
// A read of n bytes gives n beats, the last one marked; a read on an empty
// ring or of length zero gives one beat with data_valid low and last high.
// In the execution unit tick, edge and clear are done from the idle state;
// a read is first dispatched into the read state, then streams its bytes,
// the reader issuing a new byte while the last is still in flight, but only
// while the two-beat output buffer has room for the beat in flight.
// A two-entry command queue lets the input keep accepting while a read
// streams. When the receiver stalls, the output buffer fills, the reader
// halts, then the queue fills and item_ready drops.
// Reset clears counter, pointers, queue and output buffer at once; ring
// contents are not cleared and are only read after being written.
`default_nettype none
module flux_interval_capture_ring
    import fic_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic [1:0]         action,
    input  wire logic [LEN_W-1:0]   read_length,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic [DATA_W-1:0]       data,
    output logic                    data_valid,
    output logic                    last
);

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic cmd_pop;
    cmd_t head;
    logic head_valid;

    fic_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .action      (action),
        .read_length (read_length),
        .push        (push),
        .push_cmd    (push_cmd),
        .queue_full  (queue_full)
    );

    fic_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (cmd_pop),
        .head      (head),
        .not_empty (head_valid)
    );

    fic_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head),
        .cmd_valid    (head_valid),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .data         (data),
        .data_valid   (data_valid),
        .last         (last)
    );

endmodule
`default_nettype wire

@@ dv/flux_interval_capture_ring_tb.sv @@
`default_nettype none
module flux_interval_capture_ring_tb;
    import fic_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
        logic              last;
    } beat_t;

    class capture_ring_model;
        logic [DATA_W-1:0] interval_count;
        int                wr_ptr;
        int                rd_ptr;
        logic [DATA_W-1:0] ring [BUFFER_DEPTH];
        beat_t             pending_beats [$];
        int                mismatches;
        int                beats_checked;
        int                items_taken;
        int                reads_seen;
        int                empty_reads;

        function new();
            interval_count = '0;
            wr_ptr = 0;
            rd_ptr = 0;
            mismatches = 0;
            beats_checked = 0;
            items_taken = 0;
            reads_seen = 0;
            empty_reads = 0;
        endfunction

        function int ring_next(int p);
            return (p == BUFFER_DEPTH - 1) ? 0 : p + 1;
        endfunction

        function void take_item(action_t act, logic [LEN_W-1:0] len);
            int    want;
            int    avail;
            int    n;
            beat_t b;
            items_taken++;
            case (act)
                ACT_TICK:
                begin
                    interval_count = interval_count + 1'b1;
                end
                ACT_EDGE:
                begin
                    ring[wr_ptr] = interval_count;
                    interval_count = '0;
                    wr_ptr = ring_next(wr_ptr);
                end
                ACT_READ:
                begin
                    reads_seen++;
                    want = (int'(len) > MAX_READ) ? MAX_READ : int'(len);
                    avail = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr
                                               : BUFFER_DEPTH - rd_ptr + wr_ptr;
                    n = (want < avail) ? want : avail;
                    if (n == 0)
                    begin
                        empty_reads++;
                        b.data = '0;
                        b.valid = 1'b0;
                        b.last = 1'b1;
                        pending_beats.push_back(b);
                    end
                    else
                    begin
                        for (int k = 0; k < n; k++)
                        begin
                            b.data = ring[rd_ptr];
                            b.valid = 1'b1;
                            b.last = (k == n - 1);
                            pending_beats.push_back(b);
                            rd_ptr = ring_next(rd_ptr);
                        end
                    end
                end
                default:
                begin
                    interval_count = '0;
                    wr_ptr = 0;
                    rd_ptr = 0;
                end
            endcase
        endfunction

        function void check_beat(logic [DATA_W-1:0] d, logic v, logic l);
            beat_t exp_beat;
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat: expected none, got data=%h valid=%b last=%b",
                         $time, d, v, l);
                return;
            end
            exp_beat = pending_beats.pop_front();
            beats_checked++;
            if (exp_beat.data !== d || exp_beat.valid !== v || exp_beat.last !== l)
            begin
                mismatches++;
                $display("%0t: beat mismatch: expected data=%h valid=%b last=%b,",
                         $time, exp_beat.data, exp_beat.valid, exp_beat.last,
                         " got data=%h valid=%b last=%b", d, v, l);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    logic [1:0]        action;
    logic [LEN_W-1:0]  read_length;
    logic              result_valid;
    logic              result_ready;
    logic [DATA_W-1:0] data;
    logic              data_valid;
    logic              last;

    capture_ring_model ring_model;
    int                send_idle_pct;
    int                rx_stall_pct;
    int                rx_hold;

    flux_interval_capture_ring DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .read_length  (read_length),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .data         (data),
        .data_valid   (data_valid),
        .last         (last)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                ring_model.take_item(action_t'(action), read_length);
            if (result_valid && result_ready)
                ring_model.check_beat(data, data_valid, last);
        end
    end

    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                result_ready <= 1'b0;
                rx_hold--;
            end
            else
                result_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 15)
            return LEN_W'($urandom_range(MAX_READ + 1, (1 << LEN_W) - 1));
        if (r < 70)
            return LEN_W'($urandom_range(1, 12));
        return LEN_W'($urandom_range(1, MAX_READ));
    endfunction

    task automatic send_item(action_t act, logic [LEN_W-1:0] len);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        action <= act;
        read_length <= len;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic send_ticks(int count);
        repeat (count)
            send_item(ACT_TICK, LEN_W'($urandom));
    endtask

    task automatic capture_edges(int edges);
        repeat (edges)
        begin
            send_ticks($urandom_range(0, 2));
            send_item(ACT_EDGE, LEN_W'($urandom));
        end
    endtask

    task automatic send_random(int count);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_item(ACT_TICK, LEN_W'($urandom));
            else if (r < 70)
                send_item(ACT_EDGE, LEN_W'($urandom));
            else if (r < 95)
                send_item(ACT_READ, pick_length());
            else
                send_item(ACT_CLEAR, LEN_W'($urandom));
        end
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (ring_model.pending_beats.size() != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);
    endtask

    initial
    begin
        ring_model = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        action = ACT_TICK;
        read_length = '0;
        send_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        send_item(ACT_READ, 7'd5);
        send_item(ACT_TICK, 7'd127);
        send_item(ACT_TICK, 7'd0);
        send_item(ACT_EDGE, 7'd127);
        send_item(ACT_EDGE, 7'd0);
        send_item(ACT_TICK, 7'd64);
        send_item(ACT_EDGE, 7'd1);
        send_item(ACT_READ, 7'd0);
        send_item(ACT_READ, 7'd1);
        send_item(ACT_READ, 7'd127);
        send_item(ACT_READ, 7'd64);
        send_item(ACT_TICK, 7'd3);
        send_item(ACT_EDGE, 7'd3);
        send_item(ACT_CLEAR, 7'd127);
        send_item(ACT_READ, 7'd3);
        send_item(ACT_TICK, 7'd0);
        send_item(ACT_EDGE, 7'd0);
        send_item(ACT_READ, 7'd64);
        wait_for_results();

        send_random(50);
        wait_for_results();
        send_idle_pct = 88;
        send_random(50);
        wait_for_results();
        send_idle_pct = 0;
        rx_stall_pct = 88;
        send_random(50);
        wait_for_results();
        send_idle_pct = 16;
        rx_stall_pct = 16;
        send_random(50);
        wait_for_results();

        // hold off the receiver so the output buffer and command queue back up
        send_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold = 400;
        capture_edges(24);
        repeat (8)
            send_item(ACT_READ, 7'd8);
        send_item(ACT_READ, 7'd64);
        wait_for_results();

        $display("checked %0d result beats against %0d input beats (%0d reads, %0d empty)",
                 ring_model.beats_checked, ring_model.items_taken,
                 ring_model.reads_seen, ring_model.empty_reads);
        $display("covered empty, zero-length and saturated reads, clears, idle and stall mixes");
        if (ring_model.mismatches == 0 && ring_model.pending_beats.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
